### hdl/cpor_pkg.sv
// shared constants for the circle pair overlap resolver
`timescale 1ns / 1ps
`default_nettype none
package cpor_pkg;
	localparam int COORD_WIDTH_DEF = 24;
	localparam int RADIUS_W = 16;
	localparam int CD_W = 17;
	localparam int MAG_W = 17;
	localparam int FRAC_W = 8;
	localparam int NUDGE_Q8 = 26;
	localparam int DXN_W = 6;
	localparam int SQ_W = 34;
	localparam int RAD_W = 50;
	localparam int ROOT_W = 25;
	localparam int OV_W = 26;
	localparam int PROD_W = 42;
	localparam int NUM_W = 43;
	localparam int DEN_W = 26;
	localparam int QUO_W = 20;
	localparam int PUSH_W = 21;
endpackage
`default_nettype wire

### hdl/cpor_delay.sv
// register delay line for side data that rides beside a long arithmetic unit
`timescale 1ns / 1ps
`default_nettype none
module cpor_delay #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);
	logic [W-1:0] line_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[DEPTH-1];
endmodule
`default_nettype wire

### hdl/cpor_sqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module cpor_sqrt (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic [cpor_pkg::RAD_W-1:0]     radicand,
	output logic      [cpor_pkg::ROOT_W-1:0]    root
);
	localparam int RW = cpor_pkg::RAD_W;
	localparam int TW = cpor_pkg::ROOT_W;
	localparam int MW = TW + 2;

	logic [RW-1:0] rad_q  [0:TW-1];
	logic [MW-1:0] rem_q  [0:TW-1];
	logic [TW-1:0] root_q [0:TW-1];

	for (genvar i = 0; i < TW; i++) begin : g_stage
		logic [RW-1:0] rad_in;
		logic [MW-1:0] rem_in;
		logic [TW-1:0] root_in;
		logic [MW-1:0] rem_sh;
		logic [MW-1:0] trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign rad_in  = radicand;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rad_in  = rad_q[i-1];
			assign rem_in  = rem_q[i-1];
			assign root_in = root_q[i-1];
		end

		assign rem_sh = {rem_in[MW-3:0], rad_in[RW-1 -: 2]};
		assign trial  = {root_in, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[i]  <= {rad_in[RW-3:0], 2'b00};
				rem_q[i]  <= ge ? (rem_sh - trial) : rem_sh;
				root_q[i] <= {root_in[TW-2:0], ge};
			end
		end
	end

	assign root = root_q[TW-1];
endmodule
`default_nettype wire

### hdl/cpor_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module cpor_div (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [cpor_pkg::NUM_W-1:0]   num,
	input  wire logic [cpor_pkg::DEN_W-1:0]   den,
	output logic      [cpor_pkg::QUO_W-1:0]   quo
);
	localparam int NW = cpor_pkg::NUM_W;
	localparam int DW = cpor_pkg::DEN_W;
	localparam int QW = cpor_pkg::QUO_W;
	localparam int HW = NW - QW;

	// quotient is known to fit in QW bits, so the top part starts below den
	logic [QW-1:0] low_q [0:QW-1];
	logic [DW-1:0] rem_q [0:QW-1];
	logic [DW-1:0] den_q [0:QW-1];
	logic [QW-1:0] quo_q [0:QW-1];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [QW-1:0] low_in;
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] quo_in;
		logic [DW:0]   rem_sh;
		logic          ge;

		if (i == 0) begin : g_first
			assign low_in = num[QW-1:0];
			assign rem_in = DW'(num[NW-1 -: HW]);
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign low_in = low_q[i-1];
			assign rem_in = rem_q[i-1];
			assign den_in = den_q[i-1];
			assign quo_in = quo_q[i-1];
		end

		assign rem_sh = {rem_in, low_in[QW-1]};
		assign ge     = (rem_sh >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				low_q[i] <= {low_in[QW-2:0], 1'b0};
				rem_q[i] <= ge ? DW'(rem_sh - {1'b0, den_in}) : DW'(rem_sh);
				den_q[i] <= den_in;
				quo_q[i] <= {quo_in[QW-2:0], ge};
			end
		end
	end

	assign quo = quo_q[QW-1];
endmodule
`default_nettype wire

### hdl/circle_pair_overlap_resolver_unit.sv
// top level: streaming circle pair overlap resolver
//
// channel | dir | handshake                | payload
// s_*     | in  | s_tvalid / s_tready      | s_tdata: circle pair
// m_*     | out | m_tvalid / m_tready      | m_tdata: resolved centres, m_tuser: collided
//
// one pair enters per cycle while the output is not stalled; the datapath holds the
// bit-per-stage square root and divider pipelines
// arst_n clears only the valid line; payload registers start undefined
// a stall at the output freezes every stage at once, so nothing is lost or repeated
`timescale 1ns / 1ps
`default_nettype none
module circle_pair_overlap_resolver_unit #(
	parameter int COORD_WIDTH = cpor_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    s_tvalid,
	output logic                                         s_tready,
	// first_x, first_y, first_radius, second_x, second_y, second_radius
	input  wire logic [((4*COORD_WIDTH+32+7)/8)*8-1:0]   s_tdata,
	output logic                                         m_tvalid,
	input  wire logic                                    m_tready,
	// new_first_x, new_first_y, new_second_x, new_second_y
	output logic      [((4*COORD_WIDTH+7)/8)*8-1:0]      m_tdata,
	// collided
	output logic                                         m_tuser
);
	localparam int CW    = COORD_WIDTH;
	localparam int OUT_W = ((4*CW+7)/8)*8;
	localparam int MW    = cpor_pkg::MAG_W;
	localparam int CDW   = cpor_pkg::CD_W;
	localparam int RW    = cpor_pkg::RADIUS_W;
	localparam int SQW   = cpor_pkg::SQ_W;
	localparam int TW    = cpor_pkg::ROOT_W;
	localparam int OVW   = cpor_pkg::OV_W;
	localparam int PW    = cpor_pkg::PROD_W;
	localparam int NW    = cpor_pkg::NUM_W;
	localparam int DW    = cpor_pkg::DEN_W;
	localparam int QW    = cpor_pkg::QUO_W;
	localparam int XW    = cpor_pkg::PUSH_W;
	localparam int NXW   = cpor_pkg::DXN_W;
	localparam int FW    = cpor_pkg::FRAC_W;
	localparam int CMPW  = (CW + 1 > CDW) ? CW + 1 : CDW;
	localparam int SW    = ((CW > XW) ? CW : XW) + 2;
	localparam int LAT   = 3 + TW + 3 + QW + 1;
	localparam int SIDE3_W = 4*CW + 3 + 2*MW + CDW;
	localparam int SIDE6_W = 4*CW + 3;
	localparam logic signed [SW-1:0] MAXS = SW'((64'sd1 <<< (CW-1)) - 64'sd1);
	localparam logic signed [SW-1:0] MINS = -MAXS - SW'(1);
	localparam logic signed [CW:0]   NUDGE = (CW+1)'(cpor_pkg::NUDGE_Q8);

	// valid line and global advance
	logic [LAT-1:0] vld_q;
	logic           en;

	assign en       = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// field unpack
	logic signed [CW-1:0] in_ax, in_ay, in_bx, in_by;
	logic        [RW-1:0] in_ra, in_rb;

	assign in_ax = s_tdata[CW-1:0];
	assign in_ay = s_tdata[2*CW-1:CW];
	assign in_ra = s_tdata[2*CW+RW-1:2*CW];
	assign in_bx = s_tdata[3*CW+RW-1:2*CW+RW];
	assign in_by = s_tdata[4*CW+RW-1:3*CW+RW];
	assign in_rb = s_tdata[4*CW+2*RW-1:4*CW+RW];

	// stage 1: differences, magnitudes, coarse box test, nudged x positions
	logic signed [CW:0]   dx_w, dy_w, axp_w, bxm_w;
	logic        [CW:0]   mdx_w, mdy_w;
	logic        [CMPW-1:0] mdx_e, mdy_e, cd_e;
	logic        [CDW-1:0] cd_w;
	logic signed [CW-1:0] axn_w, bxn_w;

	always_comb begin
		dx_w  = {in_ax[CW-1], in_ax} - {in_bx[CW-1], in_bx};
		dy_w  = {in_ay[CW-1], in_ay} - {in_by[CW-1], in_by};
		mdx_w = dx_w[CW] ? (CW+1)'(-dx_w) : dx_w;
		mdy_w = dy_w[CW] ? (CW+1)'(-dy_w) : dy_w;
		cd_w  = {1'b0, in_ra} + {1'b0, in_rb};
		mdx_e = CMPW'(mdx_w);
		mdy_e = CMPW'(mdy_w);
		cd_e  = CMPW'(cd_w);
		// nudge by 0.1, saturating at the coordinate range
		axp_w = {in_ax[CW-1], in_ax} + NUDGE;
		bxm_w = {in_bx[CW-1], in_bx} - NUDGE;
		axn_w = (axp_w[CW] != axp_w[CW-1]) ? MAXS[CW-1:0] : axp_w[CW-1:0];
		bxn_w = (bxm_w[CW] != bxm_w[CW-1]) ? MINS[CW-1:0] : bxm_w[CW-1:0];
	end

	logic signed [CW-1:0] ax_s1, ay_s1, bx_s1, by_s1, axn_s1, bxn_s1;
	logic        [CDW-1:0] cd_s1;
	logic        [MW-1:0] mdx_s1, mdy_s1;
	logic                 sx_s1, sy_s1, small_s1, zero_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1    <= in_ax;
			ay_s1    <= in_ay;
			bx_s1    <= in_bx;
			by_s1    <= in_by;
			axn_s1   <= axn_w;
			bxn_s1   <= bxn_w;
			cd_s1    <= cd_w;
			mdx_s1   <= mdx_e[MW-1:0];
			mdy_s1   <= mdy_e[MW-1:0];
			sx_s1    <= dx_w[CW];
			sy_s1    <= dy_w[CW];
			small_s1 <= (mdx_e < cd_e) && (mdy_e < cd_e);
			zero_s1  <= (dx_w == '0) && (dy_w == '0);
		end
	end

	// stage 2: squares
	logic signed [CW:0] dxn_w;
	assign dxn_w = {axn_s1[CW-1], axn_s1} - {bxn_s1[CW-1], bxn_s1};

	logic signed [CW-1:0] ax_s2, ay_s2, bx_s2, by_s2, axn_s2, bxn_s2;
	logic        [CDW-1:0] cd_s2;
	logic        [MW-1:0] mdx_s2, mdy_s2;
	logic        [SQW-1:0] sqx_s2, sqy_s2, cd2_s2;
	logic        [NXW-1:0] dxn_s2;
	logic                 sx_s2, sy_s2, small_s2, zero_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2    <= ax_s1;
			ay_s2    <= ay_s1;
			bx_s2    <= bx_s1;
			by_s2    <= by_s1;
			axn_s2   <= axn_s1;
			bxn_s2   <= bxn_s1;
			cd_s2    <= cd_s1;
			mdx_s2   <= mdx_s1;
			mdy_s2   <= mdy_s1;
			sqx_s2   <= mdx_s1 * mdx_s1;
			sqy_s2   <= mdy_s1 * mdy_s1;
			cd2_s2   <= cd_s1 * cd_s1;
			// coincident case: difference lies between 26 and 52
			dxn_s2   <= dxn_w[NXW-1:0];
			sx_s2    <= sx_s1;
			sy_s2    <= sy_s1;
			small_s2 <= small_s1;
			zero_s2  <= zero_s1;
		end
	end

	// stage 3: exact overlap test, switch to nudged centres when coincident and overlapping
	logic [SQW:0]     sq_sum;
	logic             hit_w, nz_w;
	logic [2*NXW-1:0] dxn_sq;

	always_comb begin
		sq_sum = {1'b0, sqx_s2} + {1'b0, sqy_s2};
		hit_w  = small_s2 && (sq_sum < {1'b0, cd2_s2});
		nz_w   = zero_s2 && hit_w;
		dxn_sq = dxn_s2 * dxn_s2;
	end

	logic signed [CW-1:0] ax_s3, ay_s3, bx_s3, by_s3;
	logic        [SQW-1:0] sq_s3;
	logic        [CDW-1:0] cd_s3;
	logic        [MW-1:0] mdx_s3, mdy_s3;
	logic                 sx_s3, sy_s3, hit_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s3  <= nz_w ? axn_s2 : ax_s2;
			ay_s3  <= ay_s2;
			bx_s3  <= nz_w ? bxn_s2 : bx_s2;
			by_s3  <= by_s2;
			sq_s3  <= nz_w ? SQW'(dxn_sq) : sq_sum[SQW-1:0];
			cd_s3  <= cd_s2;
			mdx_s3 <= nz_w ? MW'(dxn_s2) : mdx_s2;
			mdy_s3 <= mdy_s2;
			sx_s3  <= nz_w ? 1'b0 : sx_s2;
			sy_s3  <= sy_s2;
			hit_s3 <= hit_w;
		end
	end

	// distance in Q.8: floor(sqrt(sq << 16))
	logic [TW-1:0] dist_w;

	cpor_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand ({sq_s3, 16'b0}),
		.root     (dist_w)
	);

	logic [SIDE3_W-1:0] side3_d;
	logic signed [CW-1:0] ax_d3, ay_d3, bx_d3, by_d3;
	logic        [CDW-1:0] cd_d3;
	logic        [MW-1:0] mdx_d3, mdy_d3;
	logic                 sx_d3, sy_d3, hit_d3;

	cpor_delay #(
		.W     (SIDE3_W),
		.DEPTH (TW)
	) u_dly_sqrt (
		.clk (clk),
		.en  (en),
		.d   ({ax_s3, ay_s3, bx_s3, by_s3, hit_s3, sx_s3, sy_s3, mdx_s3, mdy_s3, cd_s3}),
		.q   (side3_d)
	);

	assign {ax_d3, ay_d3, bx_d3, by_d3, hit_d3, sx_d3, sy_d3, mdx_d3, mdy_d3, cd_d3} = side3_d;

	// stage 4: overlap = radius sum in Q.8 minus distance
	logic signed [OVW-1:0] ov_w;
	assign ov_w = $signed({1'b0, cd_d3, FW'(0)}) - $signed({1'b0, dist_w});

	logic signed [CW-1:0] ax_s4, ay_s4, bx_s4, by_s4;
	logic        [TW-1:0] mov_s4, dist_s4;
	logic        [MW-1:0] mdx_s4, mdy_s4;
	logic                 ovn_s4, sx_s4, sy_s4, hit_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s4   <= ax_d3;
			ay_s4   <= ay_d3;
			bx_s4   <= bx_d3;
			by_s4   <= by_d3;
			mov_s4  <= ov_w[OVW-1] ? TW'(-ov_w) : ov_w[TW-1:0];
			ovn_s4  <= ov_w[OVW-1];
			dist_s4 <= dist_w;
			mdx_s4  <= mdx_d3;
			mdy_s4  <= mdy_d3;
			sx_s4   <= sx_d3;
			sy_s4   <= sy_d3;
			hit_s4  <= hit_d3;
		end
	end

	// stage 5: |d| * |overlap|
	logic signed [CW-1:0] ax_s5, ay_s5, bx_s5, by_s5;
	logic        [PW-1:0] prx_s5, pry_s5;
	logic        [TW-1:0] dist_s5;
	logic                 ngx_s5, ngy_s5, hit_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s5   <= ax_s4;
			ay_s5   <= ay_s4;
			bx_s5   <= bx_s4;
			by_s5   <= by_s4;
			prx_s5  <= mdx_s4 * mov_s4;
			pry_s5  <= mdy_s4 * mov_s4;
			dist_s5 <= dist_s4;
			ngx_s5  <= sx_s4 ^ ovn_s4;
			ngy_s5  <= sy_s4 ^ ovn_s4;
			hit_s5  <= hit_s4;
		end
	end

	// stage 6: add dist for round half away from zero, divisor 2*dist
	logic signed [CW-1:0] ax_s6, ay_s6, bx_s6, by_s6;
	logic        [NW-1:0] nmx_s6, nmy_s6;
	logic        [DW-1:0] den_s6;
	logic                 ngx_s6, ngy_s6, hit_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s6  <= ax_s5;
			ay_s6  <= ay_s5;
			bx_s6  <= bx_s5;
			by_s6  <= by_s5;
			nmx_s6 <= NW'(prx_s5) + NW'(dist_s5);
			nmy_s6 <= NW'(pry_s5) + NW'(dist_s5);
			den_s6 <= {dist_s5, 1'b0};
			ngx_s6 <= ngx_s5;
			ngy_s6 <= ngy_s5;
			hit_s6 <= hit_s5;
		end
	end

	logic [QW-1:0] qx_w, qy_w;

	cpor_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (nmx_s6),
		.den (den_s6),
		.quo (qx_w)
	);

	cpor_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (nmy_s6),
		.den (den_s6),
		.quo (qy_w)
	);

	logic [SIDE6_W-1:0] side6_d;
	logic signed [CW-1:0] ax_d6, ay_d6, bx_d6, by_d6;
	logic                 ngx_d6, ngy_d6, hit_d6;

	cpor_delay #(
		.W     (SIDE6_W),
		.DEPTH (QW)
	) u_dly_div (
		.clk (clk),
		.en  (en),
		.d   ({ax_s6, ay_s6, bx_s6, by_s6, hit_s6, ngx_s6, ngy_s6}),
		.q   (side6_d)
	);

	assign {ax_d6, ay_d6, bx_d6, by_d6, hit_d6, ngx_d6, ngy_d6} = side6_d;

	// stage 7: apply push with saturation, output register
	logic signed [XW-1:0] px_w, py_w;
	logic signed [SW-1:0] sax, say, sbx, sby;
	logic signed [CW-1:0] rax, ray, rbx, rby;

	function automatic logic signed [CW-1:0] clamp(input logic signed [SW-1:0] v);
		logic signed [CW-1:0] r;
		if (v > MAXS) begin
			r = MAXS[CW-1:0];
		end else if (v < MINS) begin
			r = MINS[CW-1:0];
		end else begin
			r = v[CW-1:0];
		end
		return r;
	endfunction

	always_comb begin
		px_w = ngx_d6 ? -$signed({1'b0, qx_w}) : $signed({1'b0, qx_w});
		py_w = ngy_d6 ? -$signed({1'b0, qy_w}) : $signed({1'b0, qy_w});
		sax  = SW'(ax_d6) + SW'(px_w);
		say  = SW'(ay_d6) + SW'(py_w);
		sbx  = SW'(bx_d6) - SW'(px_w);
		sby  = SW'(by_d6) - SW'(py_w);
		rax  = hit_d6 ? clamp(sax) : ax_d6;
		ray  = hit_d6 ? clamp(say) : ay_d6;
		rbx  = hit_d6 ? clamp(sbx) : bx_d6;
		rby  = hit_d6 ? clamp(sby) : by_d6;
	end

	logic signed [CW-1:0] ax_s7, ay_s7, bx_s7, by_s7;
	logic                 hit_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s7  <= rax;
			ay_s7  <= ray;
			bx_s7  <= rbx;
			by_s7  <= rby;
			hit_s7 <= hit_d6;
		end
	end

	assign m_tdata = OUT_W'({by_s7, bx_s7, ay_s7, ax_s7});
	assign m_tuser = hit_s7;
endmodule
`default_nettype wire
